@@ rtl/msmd_pkg.sv @@
// Shared types, constants and sine table function for the multichannel sine drive.
package msmd_pkg;

  localparam int CmdW      = 2;
  localparam int ChanW     = 4;
  localparam int StepW     = 32;
  localparam int OffsetW   = 16;
  localparam int GainW     = 16;
  localparam int SampleW   = 16;
  localparam int CountW    = 5;
  localparam int TickW     = 32;
  localparam int ChanIdxW  = 6;

  localparam logic [CmdW-1:0] CmdTick    = 2'd0;
  localparam logic [CmdW-1:0] CmdWrite   = 2'd1;
  localparam logic [CmdW-1:0] CmdRestart = 2'd2;

  localparam logic [StepW-1:0]         StepReset   = 32'd6835653;
  localparam logic [OffsetW-1:0]       OffsetReset = 16'd0;
  localparam logic signed [GainW-1:0]  GainReset   = 16'sd4096;
  localparam logic [CountW-1:0]        CountReset  = 5'd16;

  localparam real HalfPi = 1.5707963267948966;

  typedef struct packed {
    logic                wr_en;
    logic                clr_tick;
    logic                inc_tick;
    logic                issue_valid;
    logic [ChanIdxW-1:0] issue_chan;
    logic                issue_last;
  } msmd_cmd_t;

  typedef struct packed {
    logic advance;
    logic busy;
  } msmd_stat_t;

  function automatic logic signed [SampleW-1:0] sine_entry(input int k, input int qbits,
                                                           input real qstep);
    int  quarter;
    int  q;
    int  r;
    int  rr;
    int  m;
    real v;
    quarter = 1 << qbits;
    q       = k >> qbits;
    r       = k & (quarter - 1);
    rr      = ((q & 1) != 0) ? (quarter - r) : r;
    v       = 32767.0 * $sin(real'(rr) * qstep);
    m       = $rtoi(v + 0.5);
    if ((q & 2) != 0) begin
      m = -m;
    end
    return SampleW'(m);
  endfunction

endpackage

@@ rtl/msmd_ctrl.sv @@
// Controller: command decode, channel sequencing and channel count register.
module msmd_ctrl import msmd_pkg::*; #(
  parameter int CHANNELS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CountW-1:0] cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [CmdW-1:0]   command_i,
  input  msmd_stat_t        stat_i,
  output msmd_cmd_t         cmd_o
);

  localparam int ChanBits = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StIssue = 2'd1;
  localparam logic [1:0] StDrain = 2'd2;

  logic [1:0]          state_q, state_d;
  logic [ChanBits-1:0] chan_q, chan_d;
  logic [CountW-1:0]   n_q, n_d;
  logic [CountW-1:0]   count_q;
  logic [CountW-1:0]   n_eff;
  logic                accept;
  logic                is_last;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == StIdle);
  assign accept      = in_valid_i && in_ready_o;
  assign n_eff       = (int'(count_q) > CHANNELS) ? CountW'(CHANNELS) : count_q;
  assign is_last     = ((7'(chan_q) + 7'd1) == 7'(n_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CountReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      count_q <= cfg_data_i;
    end
  end

  always_comb begin
    state_d = state_q;
    chan_d  = chan_q;
    n_d     = n_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          unique case (command_i)
            CmdTick: begin
              if (n_eff == '0) begin
                cmd_o.inc_tick = 1'b1;
              end else begin
                state_d = StIssue;
                chan_d  = '0;
                n_d     = n_eff;
              end
            end
            CmdWrite:   cmd_o.wr_en    = 1'b1;
            CmdRestart: cmd_o.clr_tick = 1'b1;
            default: ;
          endcase
        end
      end
      StIssue: begin
        if (stat_i.advance) begin
          cmd_o.issue_valid = 1'b1;
          cmd_o.issue_chan  = ChanIdxW'(chan_q);
          cmd_o.issue_last  = is_last;
          if (is_last) begin
            state_d = StDrain;
          end else begin
            chan_d = chan_q + ChanBits'(1);
          end
        end
      end
      StDrain: begin
        if (!stat_i.busy) begin
          cmd_o.inc_tick = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      chan_q  <= '0;
      n_q     <= '0;
    end else begin
      state_q <= state_d;
      chan_q  <= chan_d;
      n_q     <= n_d;
    end
  end

endmodule

@@ rtl/msmd_datapath.sv @@
// Datapath: channel settings memory, tick counter, angle, sine lookup, gain and output register.
module msmd_datapath import msmd_pkg::*; #(
  parameter int CHANNELS        = 16,
  parameter int SINE_INDEX_BITS = 12
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  msmd_cmd_t                 cmd_i,
  output msmd_stat_t                stat_o,
  input  logic [ChanW-1:0]          channel_i,
  input  logic [StepW-1:0]          phase_step_i,
  input  logic [OffsetW-1:0]        phase_offset_i,
  input  logic signed [GainW-1:0]   gain_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [ChanW-1:0]          out_channel_o,
  output logic signed [SampleW-1:0] sample_o,
  output logic                      last_o
);

  localparam int  ChanBits    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int  SineSize    = 1 << SINE_INDEX_BITS;
  localparam int  QuarterBits = SINE_INDEX_BITS - 2;
  localparam int  Quarter     = 1 << QuarterBits;
  localparam real QuarterStep = HalfPi / Quarter;

  logic [StepW-1:0]         step_mem   [CHANNELS];
  logic [OffsetW-1:0]       offset_mem [CHANNELS];
  logic signed [GainW-1:0]  gain_mem   [CHANNELS];
  logic [CHANNELS-1:0]      ent_valid_q;
  logic signed [SampleW-1:0] sine_rom  [SineSize];

  logic [TickW-1:0]   tick_q;
  logic               advance;
  logic               wr_ok;
  logic [ChanBits-1:0] wr_addr;
  logic [ChanBits-1:0] rd_addr;

  logic                      v0_q, v1_q, v2_q, v3_q, out_valid_q;
  logic [ChanW-1:0]          ch0_q, ch1_q, ch2_q, ch3_q, out_ch_q;
  logic                      l0_q, l1_q, l2_q, l3_q, out_last_q;
  logic                      hit0_q;
  logic [StepW-1:0]          step0_q;
  logic [OffsetW-1:0]        off0_q, off1_q;
  logic signed [GainW-1:0]   gain0_q, gain1_q, gain2_q;
  logic [StepW-1:0]          step_eff;
  logic [OffsetW-1:0]        off_eff;
  logic signed [GainW-1:0]   gain_eff;
  logic [TickW-1:0]          prod1_q;
  logic [TickW-1:0]          angle;
  logic signed [SampleW-1:0] sine2_q;
  logic signed [31:0]        prod3_q;
  logic signed [16:0]        shifted;
  logic signed [SampleW-1:0] sat;
  logic signed [SampleW-1:0] out_sample_q;

  for (genvar k = 0; k < SineSize; k++) begin : g_rom
    assign sine_rom[k] = sine_entry(k, QuarterBits, QuarterStep);
  end

  assign advance = !out_valid_q || out_ready_i;
  assign wr_ok   = cmd_i.wr_en && (int'(channel_i) < CHANNELS);
  assign wr_addr = ChanBits'(channel_i);
  assign rd_addr = ChanBits'(cmd_i.issue_chan);

  assign stat_o.advance = advance;
  assign stat_o.busy    = v0_q || v1_q || v2_q || v3_q;

  always_ff @(posedge clk_i) begin
    if (wr_ok) begin
      step_mem[wr_addr]   <= phase_step_i;
      offset_mem[wr_addr] <= phase_offset_i;
      gain_mem[wr_addr]   <= gain_i;
    end
    if (advance) begin
      step0_q <= step_mem[rd_addr];
      off0_q  <= offset_mem[rd_addr];
      gain0_q <= gain_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_valid_q <= '0;
    end else if (wr_ok) begin
      ent_valid_q[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= '0;
    end else if (cmd_i.clr_tick) begin
      tick_q <= '0;
    end else if (cmd_i.inc_tick) begin
      tick_q <= tick_q + TickW'(1);
    end
  end

  assign step_eff = hit0_q ? step0_q : StepReset;
  assign off_eff  = hit0_q ? off0_q  : OffsetReset;
  assign gain_eff = hit0_q ? gain0_q : GainReset;
  assign angle    = prod1_q + {off1_q, 16'd0};
  assign shifted  = 17'(prod3_q >>> 15);
  assign sat      = (shifted > 17'sd32767)  ? 16'sh7fff :
                    (shifted < -17'sd32768) ? 16'sh8000 : shifted[15:0];

  always_ff @(posedge clk_i) begin
    if (advance) begin
      hit0_q       <= ent_valid_q[rd_addr];
      ch0_q        <= ChanW'(cmd_i.issue_chan);
      l0_q         <= cmd_i.issue_last;
      prod1_q      <= tick_q * step_eff;
      off1_q       <= off_eff;
      gain1_q      <= gain_eff;
      ch1_q        <= ch0_q;
      l1_q         <= l0_q;
      sine2_q      <= sine_rom[angle[TickW-1 -: SINE_INDEX_BITS]];
      gain2_q      <= gain1_q;
      ch2_q        <= ch1_q;
      l2_q         <= l1_q;
      prod3_q      <= sine2_q * gain2_q;
      ch3_q        <= ch2_q;
      l3_q         <= l2_q;
      out_sample_q <= sat;
      out_ch_q     <= ch3_q;
      out_last_q   <= l3_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q        <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      v0_q        <= cmd_i.issue_valid;
      v1_q        <= v0_q;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      out_valid_q <= v3_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_channel_o = out_ch_q;
  assign sample_o      = out_sample_q;
  assign last_o        = out_last_q;

endmodule

@@ rtl/multichannel_sine_motor_drive.sv @@
// Top level of the multichannel sine drive.
// A tick item sends channel_count channels (at most CHANNELS) into the
// five-stage pipe (settings read, angle multiply, sine lookup, gain multiply,
// output), one per cycle while the output is not stalled, then the tick counter
// advances once the pipe drains. Write, restart and empty ticks do not use the pipe.
// Reset clears control state; settings read as their defaults until written.
module multichannel_sine_motor_drive import msmd_pkg::*; #(
  parameter int CHANNELS        = 16,
  parameter int SINE_INDEX_BITS = 12
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CountW-1:0]         cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [CmdW-1:0]           command_i,
  input  logic [ChanW-1:0]          channel_i,
  input  logic [StepW-1:0]          phase_step_i,
  input  logic [OffsetW-1:0]        phase_offset_i,
  input  logic signed [GainW-1:0]   gain_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [ChanW-1:0]          out_channel_o,
  output logic signed [SampleW-1:0] sample_o,
  output logic                      last_o
);

  msmd_cmd_t  cmd;
  msmd_stat_t stat;

  msmd_ctrl #(
    .CHANNELS(CHANNELS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .command_i  (command_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  msmd_datapath #(
    .CHANNELS       (CHANNELS),
    .SINE_INDEX_BITS(SINE_INDEX_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .channel_i     (channel_i),
    .phase_step_i  (phase_step_i),
    .phase_offset_i(phase_offset_i),
    .gain_i        (gain_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_channel_o (out_channel_o),
    .sample_o      (sample_o),
    .last_o        (last_o)
  );

endmodule

@@ test/tb.sv @@
// Testbench for the multichannel sine drive: directed table, then randomized phases.
module tb import msmd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Channels      = 16;
  localparam int Predicted     = -1;
  localparam int SettleCycles  = 40;
  localparam int QuietLimit    = 2000;
  localparam int HoldCycles    = 300;
  localparam int PhaseItems    = 70;
  localparam logic [CmdW-1:0] CmdUnused = 2'd3;
  localparam bit [63:0] PiQ62  = 64'hC90FDAA22168C235;
  localparam bit [63:0] OneQ62 = 64'h4000000000000000;

  typedef enum logic {RowItem, RowCfg} row_kind_e;

  typedef struct {
    row_kind_e                kind;
    logic [CmdW-1:0]          cmd;
    logic [ChanW-1:0]         chan;
    logic [StepW-1:0]         step;
    logic [OffsetW-1:0]       offs;
    logic signed [GainW-1:0]  gain;
    int                       exp_n;
    logic signed [SampleW-1:0] exp_s;
    logic [CountW-1:0]        cfg;
  } row_t;

  typedef struct {
    logic [ChanW-1:0]          chan;
    logic signed [SampleW-1:0] value;
    logic                      last;
  } drive_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      cfg_valid_i = 1'b0;
  logic                      cfg_ready_o;
  logic [CountW-1:0]         cfg_data_i = '0;
  logic                      in_valid_i = 1'b0;
  logic                      in_ready_o;
  logic [CmdW-1:0]           command_i = '0;
  logic [ChanW-1:0]          channel_i = '0;
  logic [StepW-1:0]          phase_step_i = '0;
  logic [OffsetW-1:0]        phase_offset_i = '0;
  logic signed [GainW-1:0]   gain_i = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic [ChanW-1:0]          out_channel_o;
  logic signed [SampleW-1:0] sample_o;
  logic                      last_o;

  logic signed [SampleW-1:0] sine_lut [4096];
  bit [TickW-1:0]            tick_ctr;
  bit [StepW-1:0]            chan_step [Channels];
  bit [OffsetW-1:0]          chan_offset [Channels];
  logic signed [GainW-1:0]   chan_gain [Channels];
  bit [CountW-1:0]           active_chans;

  drive_t pending_samples[$];
  drive_t want;
  int     mismatches = 0;
  int     quiet_cycles = 0;
  int     send_gap_pct = 9;
  int     recv_stall_pct = 48;
  int     hold_asked = 0;
  int     hold_served = 0;
  int     hold_left = 0;

  row_t dir_rows [26] = '{
    '{RowItem, CmdTick,    4'd0,  32'd0,          16'h0000, 16'sh0000, 16,        16'sh0000, 5'd0},
    '{RowItem, CmdTick,    4'd0,  32'd0,          16'h0000, 16'sh0000, Predicted, 16'sh0000, 5'd0},
    '{RowItem, CmdUnused,  4'd0,  32'd0,          16'h0000, 16'sh0000, Predicted, 16'sh0000, 5'd0},
    '{RowItem, CmdRestart, 4'd0,  32'd0,          16'h0000, 16'sh0000, Predicted, 16'sh0000, 5'd0},
    '{RowItem, CmdTick,    4'd0,  32'd0,          16'h0000, 16'sh0000, 16,        16'sh0000, 5'd0},
    '{RowCfg,  CmdTick,    4'd0,  32'd0,          16'h0000, 16'sh0000, Predicted, 16'sh0000, 5'd1},
    '{RowItem, CmdWrite,   4'd0,  32'd0,          16'h4000, 16'sh7FFF, Predicted, 16'sh0000, 5'd0},
    '{RowItem, CmdTick,    4'd0,  32'd0,          16'h0000, 16'sh0000, 1,         16'sh7FFE, 5'd0},
    '{RowItem, CmdWrite,   4'd0,  32'd0,          16'h4000, 16'sh8000, Predicted, 16'sh0000, 5'd0},
    '{RowItem, CmdTick,    4'd0,  32'd0,          16'h0000, 16'sh0000, 1,         16'sh8001, 5'd0},
    '{RowItem, CmdWrite,   4'd0,  32'd0,          16'hC000, 16'sh8000, Predicted, 16'sh0000, 5'd0},
    '{RowItem, CmdTick,    4'd0,  32'd0,          16'h0000, 16'sh0000, 1,         16'sh7FFF, 5'd0},
    '{RowItem, CmdWrite,   4'd0,  32'd0,          16'hC000, 16'sh7FFF, Predicted, 16'sh0000, 5'd0},
    '{RowItem, CmdTick,    4'd0,  32'd0,          16'h0000, 16'sh0000, 1,         16'sh8001, 5'd0},
    '{RowItem, CmdWrite,   4'd0,  32'd0,          16'hC000, 16'sh0000, Predicted, 16'sh0000, 5'd0},
    '{RowItem, CmdTick,    4'd0,  32'd0,          16'h0000, 16'sh0000, 1,         16'sh0000, 5'd0},
    '{RowItem, CmdWrite,   4'd15, 32'hFFFFFFFF,   16'hFFFF, 16'sh7FFF, Predicted, 16'sh0000, 5'd0},
    '{RowCfg,  CmdTick,    4'd0,  32'd0,          16'h0000, 16'sh0000, Predicted, 16'sh0000, 5'd0},
    '{RowItem, CmdTick,    4'd0,  32'd0,          16'h0000, 16'sh0000, 0,         16'sh0000, 5'd0},
    '{RowCfg,  CmdTick,    4'd0,  32'd0,          16'h0000, 16'sh0000, Predicted, 16'sh0000, 5'd31},
    '{RowItem, CmdTick,    4'd0,  32'd0,          16'h0000, 16'sh0000, Predicted, 16'sh0000, 5'd0},
    '{RowItem, CmdWrite,   4'd10, 32'h80000000,   16'h8000, 16'shFFFF, Predicted, 16'sh0000, 5'd0},
    '{RowCfg,  CmdTick,    4'd0,  32'd0,          16'h0000, 16'sh0000, Predicted, 16'sh0000, 5'd17},
    '{RowItem, CmdTick,    4'd0,  32'd0,          16'h0000, 16'sh0000, Predicted, 16'sh0000, 5'd0},
    '{RowItem, CmdRestart, 4'd0,  32'd0,          16'h0000, 16'sh0000, Predicted, 16'sh0000, 5'd0},
    '{RowItem, CmdTick,    4'd0,  32'd0,          16'h0000, 16'sh0000, Predicted, 16'sh0000, 5'd0}
  };

  multichannel_sine_motor_drive #(
    .CHANNELS        (Channels),
    .SINE_INDEX_BITS (12)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .channel_i      (channel_i),
    .phase_step_i   (phase_step_i),
    .phase_offset_i (phase_offset_i),
    .gain_i         (gain_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_channel_o  (out_channel_o),
    .sample_o       (sample_o),
    .last_o         (last_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic bit [63:0] q62_mul(input bit [63:0] a, input bit [63:0] b);
    bit [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  function automatic logic signed [SampleW-1:0] quarter_wave(input int unsigned r);
    bit [63:0]   lowp;
    bit [63:0]   x;
    bit [63:0]   x2;
    bit [63:0]   term;
    bit [63:0]   sum;
    bit [63:0]   scaled;
    int unsigned n;
    bit          neg;
    lowp = PiQ62 & ((64'd1 << 11) - 64'd1);
    x    = (PiQ62 >> 11) * 64'(r) + ((lowp * 64'(r)) >> 11);
    if (x > OneQ62 * 64'd2 - 64'd1) begin
      x = OneQ62 * 64'd2 - 64'd1;
    end
    x2   = q62_mul(x, x);
    term = x;
    sum  = x;
    n    = 1;
    neg  = 1'b1;
    while (term != 64'd0 && n < 64) begin
      term = q62_mul(term, x2) / 64'((n + 1) * (n + 2));
      n    = n + 2;
      sum  = neg ? sum - term : sum + term;
      neg  = !neg;
    end
    if (sum > OneQ62) begin
      sum = OneQ62;
    end
    scaled = (sum >> 20) * 64'd32767 + (64'd1 << 41);
    return SampleW'(scaled >> 42);
  endfunction

  function automatic void model_item(input row_t it, ref drive_t res[$]);
    int unsigned               n;
    bit [TickW-1:0]            angle;
    logic signed [SampleW-1:0] s;
    int                        prod;
    int                        v;
    case (it.cmd)
      CmdWrite: begin
        chan_step[it.chan]   = it.step;
        chan_offset[it.chan] = it.offs;
        chan_gain[it.chan]   = it.gain;
      end
      CmdRestart: tick_ctr = '0;
      CmdTick: begin
        n = (active_chans > Channels) ? Channels : active_chans;
        for (int c = 0; c < n; c++) begin
          angle = tick_ctr * chan_step[c] + {chan_offset[c], 16'd0};
          s     = sine_lut[angle[31:20]];
          prod  = s * chan_gain[c];
          v     = prod >>> 15;
          if (v > 32767) v = 32767;
          if (v < -32768) v = -32768;
          res.push_back('{chan: ChanW'(c), value: SampleW'(v), last: (c == n - 1)});
        end
        tick_ctr = tick_ctr + 1;
      end
      default: ;
    endcase
  endfunction

  function automatic row_t random_item();
    row_t        it;
    int unsigned pick;
    pick    = $urandom_range(99);
    it.kind = RowItem;
    it.cmd  = (pick < 62) ? CmdTick : (pick < 85) ? CmdWrite :
              (pick < 93) ? CmdRestart : CmdUnused;
    it.chan = ChanW'($urandom);
    it.step = ($urandom_range(1) == 0) ? $urandom : $urandom_range(1 << 24, 1);
    it.offs = OffsetW'($urandom);
    pick    = $urandom_range(9);
    it.gain = (pick == 0) ? 16'sh7FFF : (pick == 1) ? 16'sh8000 : GainW'($urandom);
    it.exp_n = Predicted;
    it.exp_s = '0;
    it.cfg   = '0;
    return it;
  endfunction

  task automatic send_item(input row_t it);
    drive_t res[$];
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_gap_pct);
    end
    in_valid_i     <= 1'b1;
    command_i      <= it.cmd;
    channel_i      <= it.chan;
    phase_step_i   <= it.step;
    phase_offset_i <= it.offs;
    gain_i         <= it.gain;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    model_item(it, res);
    if (it.exp_n == Predicted) begin
      foreach (res[i]) pending_samples.push_back(res[i]);
    end else begin
      for (int c = 0; c < it.exp_n; c++) begin
        pending_samples.push_back('{chan: ChanW'(c), value: it.exp_s, last: (c == it.exp_n - 1)});
      end
    end
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_count(input logic [CountW-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    active_chans = v;
  endtask

  always @(posedge clk_i) begin
    if (hold_served != hold_asked) begin
      hold_served = hold_asked;
      hold_left   = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left   = hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_samples.size() == 0) begin
        $display("%0t: unexpected sample: expected none, actual ch %0d value %0d last %0d",
                 $time, out_channel_o, sample_o, last_o);
        mismatches++;
      end else begin
        want = pending_samples.pop_front();
        if (out_channel_o !== want.chan) begin
          $display("%0t: channel mismatch: expected %0d, actual %0d",
                   $time, want.chan, out_channel_o);
          mismatches++;
        end
        if (sample_o !== want.value) begin
          $display("%0t: sample mismatch on ch %0d: expected %0d, actual %0d",
                   $time, want.chan, want.value, sample_o);
          mismatches++;
        end
        if (last_o !== want.last) begin
          $display("%0t: last mismatch on ch %0d: expected %0d, actual %0d",
                   $time, want.chan, want.last, last_o);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
    end
    if (quiet_cycles == QuietLimit) begin
      $display("%0t: watchdog expired with %0d samples outstanding",
               $time, pending_samples.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    row_t                      it;
    int                        sent;
    int                        q;
    int                        r;
    logic signed [SampleW-1:0] v;
    for (int k = 0; k < 4096; k++) begin
      q = k / 1024;
      r = k % 1024;
      v = ((q & 1) != 0) ? quarter_wave(1024 - r) : quarter_wave(r);
      sine_lut[k] = ((q & 2) != 0) ? -v : v;
    end
    tick_ctr     = '0;
    active_chans = CountReset;
    for (int c = 0; c < Channels; c++) begin
      chan_step[c]   = StepReset;
      chan_offset[c] = OffsetReset;
      chan_gain[c]   = GainReset;
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == RowCfg) begin
        settle();
        write_count(dir_rows[i].cfg);
      end else begin
        send_item(dir_rows[i]);
      end
    end

    for (int ph = 0; ph < 3; ph++) begin
      settle();
      send_gap_pct   = (ph == 0) ? 9 : (ph == 1) ? 48 : 0;
      recv_stall_pct = (ph == 0) ? 48 : (ph == 1) ? 9 : 0;
      write_count((ph == 0) ? CountReset : CountW'($urandom_range(31, 1)));
      sent = 0;
      while (sent < PhaseItems) begin
        it = random_item();
        // stall the output long enough to back up the pipe into the input
        if (ph == 0 && sent == 30 && hold_asked == 0) hold_asked++;
        send_item(it);
        if (it.cmd != CmdUnused) sent++;
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/msmd_pkg.sv
rtl/msmd_ctrl.sv
rtl/msmd_datapath.sv
rtl/multichannel_sine_motor_drive.sv
test/tb.sv
